// ===== src/ohlc_pkg.sv =====
// Shared types and constants of the OHLC bar aggregator.
// Widths, bar kind codes, register indexes, controller command and status.
// No dependencies.
`default_nettype none

package ohlc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PRICE_W = 40;
  localparam int unsigned BW_W    = 17;
  localparam int unsigned END_W   = TIME_W + 1;

  localparam logic [BW_W-1:0] BIN_WIDTH_RESET = BW_W'(3600);
  localparam int unsigned     MAX_GAP_BARS_DEF = 16;

  // Configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_BIN_WIDTH = APB_ADDR_W'(0);

  // Long division: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_GAP    = 2'd2
  } bar_kind_e;

  typedef struct packed {
    logic [TIME_W-1:0]  bar_time;
    logic [PRICE_W-1:0] bar_open;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [PRICE_W-1:0] bar_close;
    bar_kind_e          bar_kind;
    logic               gaps_dropped;
    logic               last_result;
  } bar_t;

  typedef struct packed {
    logic latch;       // capture the accepted trade
    logic first_bar;   // emit bar 0 and open the batch
    logic update;      // fold the trade into the current bin
    logic div_start;   // start bin-crossing division
    logic div_short;   // quotient known to be zero
    logic setup;       // advance bin end, load gap run
    logic emit_cur;    // emit the finished bin
    logic emit_gap;    // emit one gap bar
    logic emit_eob;    // emit open bin and clear the batch
  } ctrl_cmd_t;

  typedef struct packed {
    logic started;
    logic beyond;
    logic small_step;
    logic has_trade;
    logic eob;
    logic shown_zero;
    logic gap_cnt_zero;
    logic gap_cnt_last;
    logic out_free;
    logic div_done;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== src/ohlc_trade_if.sv =====
// Trade input channel: valid/ready handshake with time, price and batch mark.
// Depends on ohlc_pkg.
`default_nettype none

interface ohlc_trade_if import ohlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  trade_time;
  logic [PRICE_W-1:0] trade_price;
  logic               end_of_batch;

  modport source (output valid, trade_time, trade_price, end_of_batch, input ready);
  modport sink   (input valid, trade_time, trade_price, end_of_batch, output ready);
endinterface

`default_nettype wire

// ===== src/ohlc_bar_if.sv =====
// Bar output channel: valid/ready handshake with one candlestick bar.
// Depends on ohlc_pkg.
`default_nettype none

interface ohlc_bar_if import ohlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  bar_time;
  logic [PRICE_W-1:0] bar_open;
  logic [PRICE_W-1:0] bar_high;
  logic [PRICE_W-1:0] bar_low;
  logic [PRICE_W-1:0] bar_close;
  logic [1:0]         bar_kind;
  logic               gaps_dropped;
  logic               last_result;

  modport source (output valid, bar_time, bar_open, bar_high, bar_low, bar_close,
                  bar_kind, gaps_dropped, last_result, input ready);
  modport sink   (input valid, bar_time, bar_open, bar_high, bar_low, bar_close,
                  bar_kind, gaps_dropped, last_result, output ready);
endinterface

`default_nettype wire

// ===== src/ohlc_div.sv =====
// Restoring divider, one quotient bit per cycle, with a zero-quotient shortcut.
// Depends on ohlc_pkg.
`default_nettype none

module ohlc_div import ohlc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              short_i,
  input  wire logic [TIME_W-1:0] dividend_i,
  input  wire logic [BW_W-1:0]   divisor_i,
  output logic                   done_o,
  output logic [TIME_W-1:0]      quo_o,
  output logic [BW_W-1:0]        rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TIME_W-1:0]    quo_q;
  logic [BW_W-1:0]      rem_q;
  logic [BW_W:0]        shifted;
  logic [BW_W:0]        diff;
  logic                 fits;
  logic [BW_W-1:0]      rem_step;

  always_comb begin
    shifted  = {rem_q, quo_q[TIME_W-1]};
    diff     = shifted - {1'b0, divisor_i};
    fits     = shifted >= {1'b0, divisor_i};
    rem_step = fits ? diff[BW_W-1:0] : shifted[BW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= short_i ? '0 : DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (short_i) begin
        // dividend already below divisor
        quo_q <= '0;
        rem_q <= dividend_i[BW_W-1:0];
      end else begin
        quo_q <= dividend_i;
        rem_q <= '0;
      end
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[TIME_W-2:0], fits};
      rem_q <= rem_step;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== src/ohlc_dp.sv =====
// Datapath: trade capture, bin state, gap run counter, output bar register.
// Depends on ohlc_pkg and ohlc_div.
`default_nettype none

module ohlc_dp import ohlc_pkg::*; #(
  parameter int unsigned MAX_GAP_BARS = MAX_GAP_BARS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_cmd_t          cmd_i,
  output ctrl_stat_t              stat_o,
  input  wire logic [BW_W-1:0]    bin_width_i,
  input  wire logic [TIME_W-1:0]  trade_time_i,
  input  wire logic [PRICE_W-1:0] trade_price_i,
  input  wire logic               end_of_batch_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output bar_t                    bar_o
);

  localparam int unsigned GAP_W = $clog2(MAX_GAP_BARS + 2);

  // Captured trade
  logic [TIME_W-1:0]  t_q;
  logic [PRICE_W-1:0] p_q;
  logic               eob_q;

  // Batch state
  logic               started_q;
  logic               has_trade_q;
  logic               drop_flag_q;
  logic               drop_pend_q;
  logic [END_W-1:0]   bin_end_q;
  logic [PRICE_W-1:0] cur_open_q;
  logic [PRICE_W-1:0] cur_high_q;
  logic [PRICE_W-1:0] cur_low_q;
  logic [PRICE_W-1:0] last_price_q;
  logic [TIME_W-1:0]  last_time_q;
  logic [TIME_W-1:0]  last_bar_key_q;
  logic [TIME_W-1:0]  gap_key_q;
  logic [GAP_W-1:0]   gap_cnt_q;

  logic               out_valid_q;
  bar_t               bar_q;
  bar_t               bar_n;
  logic               load;

  logic [BW_W-1:0]    w_eff;
  logic [END_W-1:0]   t_ext;
  logic [END_W-1:0]   dm1;
  logic               beyond;
  logic               small_step;
  logic [END_W-1:0]   gaps;
  logic               drop;
  logic [GAP_W-1:0]   shown;
  logic [END_W-1:0]   new_end;
  logic [TIME_W-1:0]  gap_key_next;

  logic               div_done;
  logic [TIME_W-1:0]  quo;
  logic [BW_W-1:0]    rem;

  always_comb begin
    w_eff        = (bin_width_i == '0) ? BW_W'(1) : bin_width_i;
    t_ext        = {1'b0, t_q};
    beyond       = t_ext > bin_end_q;
    dm1          = t_ext - bin_end_q - END_W'(1);
    small_step   = dm1 < END_W'(w_eff);
    // bins crossed minus one is quo; new end lands in [t, t + w)
    gaps         = END_W'(quo) + END_W'(!has_trade_q);
    drop         = gaps > END_W'(MAX_GAP_BARS);
    shown        = drop ? GAP_W'(MAX_GAP_BARS) : gaps[GAP_W-1:0];
    new_end      = t_ext + END_W'(w_eff) - END_W'(1) - END_W'(rem);
    gap_key_next = gap_key_q + TIME_W'(w_eff);
  end

  ohlc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .short_i    (cmd_i.div_short),
    .dividend_i (dm1[TIME_W-1:0]),
    .divisor_i  (w_eff),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // Next bar to present
  always_comb begin
    bar_n.bar_time     = last_time_q;
    bar_n.bar_open     = cur_open_q;
    bar_n.bar_high     = cur_high_q;
    bar_n.bar_low      = cur_low_q;
    bar_n.bar_close    = last_price_q;
    bar_n.bar_kind     = KIND_NORMAL;
    bar_n.gaps_dropped = drop_flag_q;
    bar_n.last_result  = 1'b1;
    if (cmd_i.first_bar) begin
      bar_n.bar_time  = t_q;
      bar_n.bar_open  = p_q;
      bar_n.bar_high  = p_q;
      bar_n.bar_low   = p_q;
      bar_n.bar_close = p_q;
      bar_n.bar_kind  = KIND_FIRST;
    end else if (cmd_i.emit_cur) begin
      bar_n.last_result = (gap_cnt_q == '0) && !eob_q;
    end else if (cmd_i.emit_gap) begin
      bar_n.bar_time    = gap_key_next;
      bar_n.bar_open    = last_price_q;
      bar_n.bar_high    = last_price_q;
      bar_n.bar_low     = last_price_q;
      bar_n.bar_kind    = KIND_GAP;
      bar_n.last_result = (gap_cnt_q == GAP_W'(1)) && !eob_q;
    end
    load = cmd_i.first_bar | cmd_i.emit_cur | cmd_i.emit_gap | cmd_i.emit_eob;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      has_trade_q <= 1'b0;
      drop_flag_q <= 1'b0;
      drop_pend_q <= 1'b0;
      gap_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.first_bar) begin
        started_q   <= !eob_q;
        has_trade_q <= 1'b0;
        drop_flag_q <= 1'b0;
      end else if (cmd_i.setup) begin
        has_trade_q <= 1'b0;
        drop_pend_q <= drop;
        gap_cnt_q   <= shown;
      end else if (cmd_i.update) begin
        has_trade_q <= 1'b1;
        drop_flag_q <= drop_flag_q | drop_pend_q;
        drop_pend_q <= 1'b0;
      end else if (cmd_i.emit_cur) begin
        drop_flag_q <= 1'b0;
      end else if (cmd_i.emit_gap) begin
        drop_flag_q <= 1'b0;
        gap_cnt_q   <= gap_cnt_q - GAP_W'(1);
      end else if (cmd_i.emit_eob) begin
        started_q   <= 1'b0;
        has_trade_q <= 1'b0;
        drop_flag_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      t_q   <= trade_time_i;
      p_q   <= trade_price_i;
      eob_q <= end_of_batch_i;
    end
    if (cmd_i.first_bar) begin
      bin_end_q      <= t_ext + END_W'(w_eff);
      last_price_q   <= p_q;
      last_time_q    <= t_q;
      last_bar_key_q <= t_q;
    end
    if (cmd_i.setup) begin
      bin_end_q <= new_end;
      gap_key_q <= has_trade_q ? last_time_q : last_bar_key_q;
    end
    if (cmd_i.update) begin
      if (!has_trade_q) begin
        cur_open_q <= last_price_q;
        cur_high_q <= p_q;
        cur_low_q  <= p_q;
      end else begin
        if (p_q > cur_high_q) begin
          cur_high_q <= p_q;
        end
        if (p_q < cur_low_q) begin
          cur_low_q <= p_q;
        end
      end
      last_price_q <= p_q;
      last_time_q  <= t_q;
    end
    if (cmd_i.emit_cur) begin
      last_bar_key_q <= last_time_q;
    end
    if (cmd_i.emit_gap) begin
      gap_key_q <= gap_key_next;
    end
    if (load) begin
      bar_q <= bar_n;
    end
  end

  always_comb begin
    stat_o.started      = started_q;
    stat_o.beyond       = beyond;
    stat_o.small_step   = small_step;
    stat_o.has_trade    = has_trade_q;
    stat_o.eob          = eob_q;
    stat_o.shown_zero   = (shown == '0);
    stat_o.gap_cnt_zero = (gap_cnt_q == '0);
    stat_o.gap_cnt_last = (gap_cnt_q == GAP_W'(1));
    stat_o.out_free     = !out_valid_q || out_ready_i;
    stat_o.div_done     = div_done;
  end

  assign out_valid_o = out_valid_q;
  assign bar_o       = bar_q;

endmodule

`default_nettype wire

// ===== src/ohlc_ctrl.sv =====
// Controller: sequences trade capture, bin crossing, bar emission and batch end.
// Depends on ohlc_pkg.
`default_nettype none

module ohlc_ctrl import ohlc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire ctrl_stat_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_SETUP  = 8'b0000_1000,
    ST_CUR    = 8'b0001_0000,
    ST_GAP    = 8'b0010_0000,
    ST_UPD    = 8'b0100_0000,
    ST_EOB    = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat_i.started) begin
          if (stat_i.out_free) begin
            cmd_o.first_bar = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (stat_i.beyond) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_short = stat_i.small_step;
          state_d         = ST_DIV;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = stat_i.eob ? ST_EOB : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (stat_i.has_trade) begin
          state_d = ST_CUR;
        end else if (!stat_i.shown_zero) begin
          state_d = ST_GAP;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_CUR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_cur = 1'b1;
          state_d        = stat_i.gap_cnt_zero ? ST_UPD : ST_GAP;
        end
      end
      ST_GAP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_gap = 1'b1;
          if (stat_i.gap_cnt_last) begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = stat_i.eob ? ST_EOB : ST_IDLE;
      end
      ST_EOB: begin
        if (stat_i.out_free) begin
          cmd_o.emit_eob = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ohlc_bar_aggregator_top.sv =====
// Top level of the OHLC bar aggregator: APB register, controller and datapath.
// Depends on ohlc_pkg, ohlc_trade_if, ohlc_bar_if, ohlc_ctrl, ohlc_dp.
//
// Use:
//   trade_i carries time-ordered trades (time, price, end_of_batch); bar_o
//   carries candlestick bars, one per beat, last_result set on the final bar
//   that a trade causes. bin_width is written over the APB port at address 0
//   while the block is idle; pready is always high, reads of address 0 return bin_width.
// Sequence:
//   A trade that stays in the current bin takes the accept beat and the
//   decision state; one past the bin end adds setup, update and one emission
//   per bar, each waiting for a free output, and, more than one bin width past
//   it, the long division (one quotient bit per cycle) first. A batch's first
//   trade loads its bar in the decision state once the output is free; a later
//   end_of_batch trade closes its bin in the batch-end state. A trade is taken
//   only when the controller is idle; one output register holds the newest
//   bar, so the next trade is taken while it waits.
// Reset:
//   bin_width returns to 3600 and the batch is cleared: the next trade starts
//   a new batch with a first-trade bar.
// Stall:
//   While bar_o.ready is low the pending bar holds and the controller waits
//   before loading the next one; no bar is lost or repeated.
`default_nettype none

module ohlc_bar_aggregator_top import ohlc_pkg::*; #(
  parameter int unsigned MAX_GAP_BARS = MAX_GAP_BARS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ohlc_trade_if.sink                 trade_i,
  ohlc_bar_if.source                 bar_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [BW_W-1:0] bin_width_q;
  ctrl_cmd_t       cmd;
  ctrl_stat_t      stat;
  bar_t            bar;
  logic            in_ready;
  logic            out_valid;

  // Configuration register: written in the access phase of an APB write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_BIN_WIDTH)) begin
      bin_width_q <= pwdata[BW_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BIN_WIDTH) ? APB_DATA_W'(bin_width_q) : '0;

  ohlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (trade_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ohlc_dp #(
    .MAX_GAP_BARS (MAX_GAP_BARS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .bin_width_i    (bin_width_q),
    .trade_time_i   (trade_i.trade_time),
    .trade_price_i  (trade_i.trade_price),
    .end_of_batch_i (trade_i.end_of_batch),
    .out_ready_i    (bar_o.ready),
    .out_valid_o    (out_valid),
    .bar_o          (bar)
  );

  assign trade_i.ready      = in_ready;
  assign bar_o.valid        = out_valid;
  assign bar_o.bar_time     = bar.bar_time;
  assign bar_o.bar_open     = bar.bar_open;
  assign bar_o.bar_high     = bar.bar_high;
  assign bar_o.bar_low      = bar.bar_low;
  assign bar_o.bar_close    = bar.bar_close;
  assign bar_o.bar_kind     = bar.bar_kind;
  assign bar_o.gaps_dropped = bar.gaps_dropped;
  assign bar_o.last_result  = bar.last_result;

endmodule

`default_nettype wire

// ===== test/ohlc_bar_checker.sv =====
// Bar checker for the OHLC bar aggregator: watches trade, bar and APB traffic,
// predicts every bar from the accepted trades and compares it beat by beat.
// Depends on ohlc_pkg, ohlc_trade_if and ohlc_bar_if.
`timescale 1ns / 100ps

module ohlc_bar_checker import ohlc_pkg::*; #(
  parameter int unsigned MAX_GAP_BARS = MAX_GAP_BARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ohlc_trade_if                 trade_mon,
  ohlc_bar_if                   bar_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int unsigned           mismatch_cnt,
  output int unsigned           pending_bars,
  output int unsigned           bars_seen,
  output int unsigned           gap_bars_seen,
  output int unsigned           capped_runs
);

  localparam int unsigned REPORT_MAX = 10;

  // Shadow of the block's register and batch state
  logic [BW_W-1:0]    width_q;
  logic               batch_open;
  logic [63:0]        bin_end_q;
  logic               bin_filled;
  logic [PRICE_W-1:0] open_q;
  logic [PRICE_W-1:0] high_q;
  logic [PRICE_W-1:0] low_q;
  logic [PRICE_W-1:0] last_px;
  logic [TIME_W-1:0]  last_t;
  logic [TIME_W-1:0]  last_key;
  logic               skip_pending;

  bar_t bars_due[$];

  task automatic clear_batch();
    batch_open   = 1'b0;
    bin_end_q    = '0;
    bin_filled   = 1'b0;
    open_q       = '0;
    high_q       = '0;
    low_q        = '0;
    last_px      = '0;
    last_t       = '0;
    last_key     = '0;
    skip_pending = 1'b0;
  endtask

  task automatic push_bar(input logic [TIME_W-1:0] key, input logic [PRICE_W-1:0] o,
                          input logic [PRICE_W-1:0] h, input logic [PRICE_W-1:0] l,
                          input logic [PRICE_W-1:0] c, input bar_kind_e kind);
    bar_t b;
    b.bar_time     = key;
    b.bar_open     = o;
    b.bar_high     = h;
    b.bar_low      = l;
    b.bar_close    = c;
    b.bar_kind     = kind;
    b.gaps_dropped = skip_pending;
    b.last_result  = 1'b0;
    skip_pending   = 1'b0;
    bars_due.insert(bars_due.size(), b);
  endtask

  task automatic close_bin();
    push_bar(last_t, open_q, high_q, low_q, last_px, KIND_NORMAL);
    last_key = last_t;
  endtask

  // Fold one accepted trade into the shadow state and queue the bars it causes
  task automatic fold_trade(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] p,
                            input logic eob);
    logic [63:0] w;
    logic [63:0] gaps;
    logic [63:0] hops;
    logic [63:0] shown;
    logic [63:0] m;
    int unsigned first_idx;
    first_idx = bars_due.size();
    w = (width_q == '0) ? 64'd1 : 64'(width_q);
    if (!batch_open) begin
      push_bar(t, p, p, p, p, KIND_FIRST);
      batch_open = 1'b1;
      bin_end_q  = 64'(t) + w;
      bin_filled = 1'b0;
      last_px    = p;
      last_t     = t;
      last_key   = t;
    end else begin
      if (64'(t) > bin_end_q) begin
        gaps = 64'd0;
        if (bin_filled) close_bin();
        else gaps = 64'd1;
        hops = (64'(t) - bin_end_q + w - 64'd1) / w;
        gaps = gaps + hops - 64'd1;
        bin_end_q = bin_end_q + hops * w;
        bin_filled = 1'b0;
        shown = (gaps > 64'(MAX_GAP_BARS)) ? 64'(MAX_GAP_BARS) : gaps;
        for (m = 64'd1; m <= shown; m++) begin
          push_bar(TIME_W'(64'(last_key) + m * w), last_px, last_px, last_px, last_px,
                   KIND_GAP);
        end
        if (gaps > 64'(MAX_GAP_BARS)) begin
          skip_pending = 1'b1;
          capped_runs++;
        end
      end
      if (!bin_filled) begin
        open_q     = last_px;
        high_q     = p;
        low_q      = p;
        bin_filled = 1'b1;
      end else begin
        if (p > high_q) high_q = p;
        if (p < low_q) low_q = p;
      end
      last_px = p;
      last_t  = t;
    end
    if (eob) begin
      if (bin_filled) close_bin();
      clear_batch();
    end
    if (bars_due.size() > first_idx) bars_due[bars_due.size()-1].last_result = 1'b1;
  endtask

  task automatic show_bar(input string tag, input bar_t b);
    $display("  %s time=%h open=%h high=%h low=%h close=%h kind=%0d dropped=%b last=%b",
             tag, b.bar_time, b.bar_open, b.bar_high, b.bar_low, b.bar_close,
             b.bar_kind, b.gaps_dropped, b.last_result);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bar_t got;
    bar_t want;
    if (!rst_ni) begin
      width_q = BIN_WIDTH_RESET;
      clear_batch();
      bars_due.delete();
      mismatch_cnt  = 0;
      bars_seen     = 0;
      gap_bars_seen = 0;
      capped_runs   = 0;
    end else begin
      // Register traffic
      if (psel && penable && pready && pwrite && paddr == REG_BIN_WIDTH)
        width_q = pwdata[BW_W-1:0];
      if (psel && penable && pready && !pwrite && paddr == REG_BIN_WIDTH &&
          prdata !== APB_DATA_W'(width_q)) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("bin_width read mismatch: expected %h actual %h",
                   APB_DATA_W'(width_q), prdata);
      end

      // Compare the bar beat against the oldest prediction
      if (bar_mon.valid && bar_mon.ready) begin
        got.bar_time     = bar_mon.bar_time;
        got.bar_open     = bar_mon.bar_open;
        got.bar_high     = bar_mon.bar_high;
        got.bar_low      = bar_mon.bar_low;
        got.bar_close    = bar_mon.bar_close;
        got.bar_kind     = bar_kind_e'(bar_mon.bar_kind);
        got.gaps_dropped = bar_mon.gaps_dropped;
        got.last_result  = bar_mon.last_result;
        bars_seen++;
        if (got.bar_kind == KIND_GAP) gap_bars_seen++;
        if (bars_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("unexpected bar at %0t", $realtime);
            show_bar("actual  ", got);
          end
        end else begin
          want = bars_due.pop_front();
          if (got.bar_time !== want.bar_time || got.bar_open !== want.bar_open ||
              got.bar_high !== want.bar_high || got.bar_low !== want.bar_low ||
              got.bar_close !== want.bar_close || got.bar_kind !== want.bar_kind ||
              got.gaps_dropped !== want.gaps_dropped ||
              got.last_result !== want.last_result) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("bar mismatch at %0t", $realtime);
              show_bar("expected", want);
              show_bar("actual  ", got);
            end
          end
        end
      end

      // Predict the bars of the trade beat
      if (trade_mon.valid && trade_mon.ready)
        fold_trade(trade_mon.trade_time, trade_mon.trade_price, trade_mon.end_of_batch);
    end
    pending_bars = bars_due.size();
  end

endmodule

// ===== test/ohlc_bar_aggregator_top_tb.sv =====
// Testbench top for the OHLC bar aggregator: clock, reset, APB writes, trade
// stimulus and bar back-pressure; the checker beside the block gives the verdict count.
// Depends on ohlc_pkg, ohlc_trade_if, ohlc_bar_if, ohlc_bar_checker, the block.
`timescale 1ns / 100ps

module ohlc_bar_aggregator_top_tb;
  import ohlc_pkg::*;

  localparam int unsigned CLK_HI         = 6;
  localparam int unsigned CLK_LO         = 6;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned IDLE_PCT       = 31;
  // Longest trade: bin crossing, 32-step division and a full gap run
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AT        = 120;
  localparam int unsigned STEADY_FROM    = 170;
  localparam int unsigned STEADY_TO      = 225;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 30;
  localparam int unsigned PHASES         = 7;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ohlc_trade_if trade_ch ();
  ohlc_bar_if   bar_ch ();

  int unsigned mismatch_cnt;
  int unsigned pending_bars;
  int unsigned bars_seen;
  int unsigned gap_bars_seen;
  int unsigned capped_runs;

  int unsigned trades_sent;
  int unsigned widths_used;
  int unsigned quiet_cycles;
  logic        steady;
  logic        hold_done;

  ohlc_bar_aggregator_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .trade_i (trade_ch),
    .bar_o   (bar_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ohlc_bar_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .trade_mon     (trade_ch),
    .bar_mon       (bar_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatch_cnt  (mismatch_cnt),
    .pending_bars  (pending_bars),
    .bars_seen     (bars_seen),
    .gap_bars_seen (gap_bars_seen),
    .capped_runs   (capped_runs)
  );

  // Free-running clock
  always begin
    #(CLK_LO) clk_i = 1'b1;
    #(CLK_HI) clk_i = 1'b0;
  end

  // Drive every input to a known value at time zero, then release reset once;
  // it is never asserted again.
  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    trade_ch.valid        = 1'b0;
    trade_ch.trade_time   = '0;
    trade_ch.trade_price  = '0;
    trade_ch.end_of_batch = 1'b0;
    bar_ch.ready          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (trade_ch.valid && trade_ch.ready) || (bar_ch.valid && bar_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // Bar sink: random back-pressure, none during the steady stretch, and one
  // long hold-off while the sender keeps offering trades so the block backs up.
  initial begin : bar_sink
    int unsigned k;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && trades_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        bar_ch.ready <= 1'b0;
        for (k = 1; k < HOLD_CYCLES; k++) @(posedge clk_i);
      end else if (steady) begin
        bar_ch.ready <= 1'b1;
      end else begin
        bar_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one trade beat, with random idle cycles ahead of it outside the steady
  // stretch, and hold it until the block takes it.
  task automatic send_trade(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] p,
                            input logic eob);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      trade_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    trade_ch.valid        <= 1'b1;
    trade_ch.trade_time   <= t;
    trade_ch.trade_price  <= p;
    trade_ch.end_of_batch <= eob;
    do @(posedge clk_i); while (!trade_ch.ready);
    trades_sent++;
    steady = (trades_sent >= STEADY_FROM && trades_sent < STEADY_TO);
  endtask

  // Drop valid, wait for every predicted bar, then let the block finish any
  // trade that caused no bar.
  task automatic wait_idle();
    trade_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_bars != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer to bin_width: setup cycle, access cycle, then release
  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_BIN_WIDTH;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_width(input logic [APB_DATA_W-1:0] word);
    apb_access(1'b1, word);
    apb_access(1'b0, '0);
    widths_used++;
  endtask

  // One batch of time-ordered trades, mostly well formed: steps within the
  // bin, into the next bin, across a short gap run or past the gap cap, plus
  // late trades and the odd arbitrary time. The last trade closes the batch.
  task automatic play_batch(input int unsigned len, input logic [63:0] w,
                            input logic near_top);
    logic [63:0]        t;
    logic [PRICE_W-1:0] p;
    int unsigned        i;
    int unsigned        pick;
    if (near_top) t = 64'(TIME_MAX) - 64'($urandom_range(0, 20 * w));
    else t = 64'($urandom);
    for (i = 0; i < len; i++) begin
      if (i > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          t = t + $urandom_range(0, w / 2);
        else if (pick < 65)
          t = t + $urandom_range(w / 2, 2 * w);
        else if (pick < 80)
          t = t + w * $urandom_range(2, 15) + $urandom_range(0, w - 1);
        else if (pick < 87)
          t = t + w * $urandom_range(17, 40);
        else if (pick < 95)
          t = (t > w) ? t - $urandom_range(0, w) : 64'd0;
        else
          t = 64'($urandom);
        if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) p = '0;
      else if (pick == 1) p = PRICE_MAX;
      else p = {8'($urandom), 32'($urandom)};
      send_trade(t[TIME_W-1:0], p, i == len - 1);
    end
  endtask

  initial begin : stimulus
    logic [APB_DATA_W-1:0] width_word[PHASES];
    logic [APB_DATA_W-1:0] word;
    logic [63:0]           w;
    int unsigned           ph;
    int unsigned           phase_start;
    int unsigned           len;

    trades_sent = 0;
    widths_used = 0;
    steady      = 1'b0;

    wait (rst_ni);
    @(posedge clk_i);

    // Reset value of bin_width must read back before any write
    apb_access(1'b0, '0);

    // Directed part at the reset width of 3600
    send_trade('0, '0, 1'b1);               // single-trade batch, all zero
    send_trade(TIME_MAX, PRICE_MAX, 1'b1);  // single-trade batch, all ones
    send_trade(32'd1000, 40'd500, 1'b0);
    send_trade(32'd1100, PRICE_MAX, 1'b0);
    send_trade(32'd1050, '0, 1'b0);         // late trade joins the bin
    send_trade(32'd4600, 40'd777, 1'b0);    // exactly on the bin end
    send_trade(32'd4601, 40'd300, 1'b0);    // crosses: normal bar
    send_trade(32'd15401, 40'd42, 1'b0);    // two empty bins in between
    send_trade(32'd123401, 40'd9, 1'b0);    // gap run past the cap
    send_trade(32'd123406, 40'd11, 1'b1);   // flagged bar, then batch end
    send_trade(32'd20000, 40'd1, 1'b0);     // empty first bin after bar 0
    send_trade(32'd27300, 40'd2, 1'b1);
    send_trade(32'd30000, 40'd5, 1'b0);     // batch ends inside a bin
    send_trade(32'd30010, 40'd6, 1'b0);
    send_trade(32'd30020, 40'd4, 1'b1);
    wait_idle();

    // Zero width acts as one second
    set_width('0);
    send_trade(32'd10, 40'd100, 1'b0);
    send_trade(32'd11, 40'd200, 1'b0);
    send_trade(32'd13, 40'd150, 1'b1);
    wait_idle();

    // Random phases over several widths, extremes first; upper pwdata bits
    // carry junk on some writes
    width_word[0] = 32'd1;
    width_word[1] = 32'd86400;
    width_word[2] = 32'hFFFF_FFFF;
    word = $urandom;
    word[BW_W-1:0] = BIN_WIDTH_RESET;
    width_word[3] = word;
    width_word[4] = $urandom_range(1, 86400);
    width_word[5] = $urandom_range(2, 50);
    width_word[6] = 32'd0;

    for (ph = 0; ph < PHASES; ph++) begin
      set_width(width_word[ph]);
      w = (width_word[ph][BW_W-1:0] == '0) ? 64'd1 : 64'(width_word[ph][BW_W-1:0]);
      phase_start = trades_sent;
      while (trades_sent - phase_start < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
        play_batch(len, w, $urandom_range(0, 9) == 0);
      end
      wait_idle();
    end

    $display("covered %0d trades over %0d bin width settings", trades_sent, widths_used + 1);
    $display("checked %0d bars, %0d gap bars, %0d capped gap runs",
             bars_seen, gap_bars_seen, capped_runs);
    if (mismatch_cnt == 0 && pending_bars == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d bars never seen", mismatch_cnt, pending_bars);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
